// ===== hw/rtl/jabc_pkg.sv =====
// shared types, constants and codes of the joystick axis and button conditioner
package jabc_pkg;

  // fixed field widths and scaling
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned AXIS_MAX    = 2048;
  localparam int unsigned FULL_SCALE  = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned OUT_W       = 13;
  localparam int unsigned AX_W        = $clog2(AXIS_MAX + 1);

  // default number of calibration samples
  localparam int unsigned CALIB_SAMPLES_DEF = 32;

  // configuration registers
  localparam int unsigned DZ_W         = 11;
  localparam int unsigned DBC_W        = 4;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 11;
  localparam logic [DZ_W-1:0]  DEADZONE_RST = DZ_W'(200);
  localparam logic [DBC_W-1:0] DEBOUNCE_RST = DBC_W'(2);

  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd1;

  // request opcodes
  typedef enum logic [1:0] {
    OP_READ        = 2'd0,
    OP_CALIB       = 2'd1,
    OP_STOP        = 2'd2,
    OP_INIT_BUTTON = 2'd3
  } op_e;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic div_start;
    logic commit;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_div;
    logic div_busy;
  } dp_sts_t;

endpackage

// ===== hw/rtl/jabc_if.sv =====
// stream interfaces of the conditioner: request, result and configuration write
interface jabc_req_if;
  import jabc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             opcode;
  logic [SAMPLE_BITS-1:0] raw_x;
  logic [SAMPLE_BITS-1:0] raw_y;
  logic                   key_raw;
  modport source (output valid, opcode, raw_x, raw_y, key_raw, input ready);
  modport sink   (input valid, opcode, raw_x, raw_y, key_raw, output ready);
endinterface

interface jabc_res_if;
  import jabc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] x_out;
  logic signed [OUT_W-1:0] y_out;
  logic                    key_held;
  logic                    key_press;
  logic                    calibration_done;
  modport source (output valid, x_out, y_out, key_held, key_press, calibration_done,
                  input ready);
  modport sink   (input valid, x_out, y_out, key_held, key_press, calibration_done,
                  output ready);
endinterface

interface jabc_cfg_if;
  import jabc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/jabc_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
module jabc_div #(
  parameter int unsigned DVD_W = 24,
  parameter int unsigned DVS_W = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W:0]   rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   rem_sh;
  logic             fits;

  // trial subtract of the shifted remainder
  assign rem_sh = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_d = {quo_q[DVD_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== hw/rtl/jabc_ctrl.sv =====
// sequencing controller of the conditioner
module jabc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic              res_ready_i,
  output logic              res_valid_o,
  input  jabc_pkg::dp_sts_t sts_i,
  output jabc_pkg::dp_cmd_t cmd_o
);

  import jabc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_LOAD   = 5'b00100,
    S_DIVIDE = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  dp_cmd_t cmd;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd.capture = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_d  = S_LOAD;
      end
      S_LOAD: begin
        if (sts_i.need_div) begin
          cmd.div_start = 1'b1;
          state_d       = S_DIVIDE;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_DIVIDE: begin
        if (!sts_i.div_busy) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || res_ready_i) begin
          cmd.commit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result slot occupancy
  always_comb begin
    if (cmd.commit) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// ===== hw/rtl/jabc_datapath.sv =====
// datapath: calibration sums, centres, deadzone and scaling, debounce, result register
module jabc_datapath #(
  parameter int unsigned CALIB_SAMPLES = jabc_pkg::CALIB_SAMPLES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  jabc_pkg::dp_cmd_t                   cmd_i,
  output jabc_pkg::dp_sts_t                   sts_o,
  input  logic                                cfg_we_i,
  input  logic [jabc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [jabc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [1:0]                          opcode_i,
  input  logic [jabc_pkg::SAMPLE_BITS-1:0]    raw_x_i,
  input  logic [jabc_pkg::SAMPLE_BITS-1:0]    raw_y_i,
  input  logic                                key_raw_i,
  output logic signed [jabc_pkg::OUT_W-1:0]   x_out_o,
  output logic signed [jabc_pkg::OUT_W-1:0]   y_out_o,
  output logic                                key_held_o,
  output logic                                key_press_o,
  output logic                                calibration_done_o
);

  import jabc_pkg::*;

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned MUL_W = SB + AX_W;
  localparam int unsigned SUM_W = SB + $clog2(CALIB_SAMPLES);
  localparam int unsigned DVD_W = (MUL_W > SUM_W) ? MUL_W : SUM_W;
  localparam int unsigned CNT_W = $clog2(CALIB_SAMPLES + 1);
  localparam int unsigned DVS_W = (SB > CNT_W) ? SB : CNT_W;

  localparam logic signed [SB+1:0] FULL_S   = (SB+2)'(FULL_SCALE);
  localparam logic [DVD_W-1:0]     AX_C     = DVD_W'(AXIS_MAX);
  localparam logic [SB-1:0]        CENTRE_R = SB'(1 << (SB - 1));

  typedef struct packed {
    logic          zero;
    logic          neg;
    logic [SB-1:0] mag;
    logic [SB-1:0] span;
  } prep_t;

  // recentre, deadzone test, span and saturated magnitude of one axis
  function automatic prep_t prep_axis(input logic [SB-1:0] raw, input logic [SB-1:0] ctr,
                                      input logic [DZ_W-1:0] dz);
    logic signed [SB+1:0] value;
    logic signed [SB+1:0] negv;
    logic signed [SB+1:0] span_s;
    logic signed [SB+1:0] dz_s;
    logic                 pos;
    logic [SB-1:0]        abs_v;
    logic [SB-1:0]        dz_e;
    logic [SB-1:0]        mag;
    prep_t                p;
    value  = $signed({2'b00, raw}) - $signed({2'b00, ctr});
    negv   = -value;
    pos    = value > 0;
    abs_v  = pos ? value[SB-1:0] : negv[SB-1:0];
    dz_e   = SB'(dz);
    dz_s   = $signed((SB+2)'(dz));
    span_s = pos ? (FULL_S - $signed({2'b00, ctr}) - dz_s) : ($signed({2'b00, ctr}) - dz_s);
    mag    = abs_v - dz_e;
    p.zero = (abs_v < dz_e) || (span_s <= 0);
    p.neg  = !pos;
    p.span = span_s[SB-1:0];
    p.mag  = (mag > p.span) ? p.span : mag;
    return p;
  endfunction

  // clamp the quotient and restore the sign
  function automatic logic signed [OUT_W-1:0] axis_result(input logic [DVD_W-1:0] quo,
                                                          input logic active,
                                                          input prep_t p);
    logic [AX_W-1:0]         sc;
    logic signed [OUT_W-1:0] v;
    sc = (quo > AX_C) ? AX_W'(AXIS_MAX) : quo[AX_W-1:0];
    v  = $signed(OUT_W'(sc));
    if (!active || p.zero) begin
      return '0;
    end
    return p.neg ? -v : v;
  endfunction

  // configuration registers
  logic [DZ_W-1:0]  deadzone_q;
  logic [DBC_W-1:0] debounce_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q <= DEADZONE_RST;
      debounce_q <= DEBOUNCE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DEADZONE: deadzone_q <= cfg_data_i[DZ_W-1:0];
        REG_DEBOUNCE: debounce_q <= cfg_data_i[DBC_W-1:0];
        default: ;
      endcase
    end
  end

  // captured request
  op_e           op_q;
  logic [SB-1:0] rx_q, ry_q;
  logic          rb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= op_e'(opcode_i);
      rx_q <= raw_x_i;
      ry_q <= raw_y_i;
      rb_q <= key_raw_i;
    end
  end

  // block state
  logic [SB-1:0]    centre_x_q, centre_y_q;
  logic [SUM_W-1:0] sum_x_q, sum_y_q;
  logic [CNT_W-1:0] calib_cnt_q;
  logic             enabled_q;
  logic             stable_q, prev_q;
  logic [DBC_W-1:0] match_q;
  logic             final_q, need_div_q, active_q, pressed_q;
  prep_t            px_q, py_q;

  // per item combinational values
  prep_t            px, py;
  logic [SUM_W-1:0] sum_x_n, sum_y_n;
  logic [CNT_W-1:0] cnt_n;
  logic             calib_full;
  logic             prev_n, stable_n;
  logic [DBC_W-1:0] match_n;

  assign px = prep_axis(rx_q, centre_x_q, deadzone_q);
  assign py = prep_axis(ry_q, centre_y_q, deadzone_q);

  assign sum_x_n    = sum_x_q + SUM_W'(rx_q);
  assign sum_y_n    = sum_y_q + SUM_W'(ry_q);
  assign cnt_n      = calib_cnt_q + CNT_W'(1);
  assign calib_full = cnt_n >= CNT_W'(CALIB_SAMPLES);

  // debounce of the sampled level
  always_comb begin
    if (rb_q == prev_q) begin
      prev_n  = prev_q;
      match_n = (match_q < debounce_q) ? (match_q + DBC_W'(1)) : match_q;
    end else begin
      prev_n  = rb_q;
      match_n = DBC_W'(1);
    end
    stable_n = (match_n >= debounce_q) ? prev_n : stable_q;
  end

  // dividers, one per axis
  logic [DVD_W-1:0] dvd_x, dvd_y, quo_x, quo_y;
  logic [DVS_W-1:0] dvs_x, dvs_y;
  logic             busy_x, busy_y;

  assign dvd_x = final_q ? DVD_W'(sum_x_q) : (DVD_W'(px_q.mag) * AX_C);
  assign dvd_y = final_q ? DVD_W'(sum_y_q) : (DVD_W'(py_q.mag) * AX_C);
  assign dvs_x = final_q ? DVS_W'(CALIB_SAMPLES) : DVS_W'(px_q.span);
  assign dvs_y = final_q ? DVS_W'(CALIB_SAMPLES) : DVS_W'(py_q.span);

  jabc_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd_x),
    .divisor_i  (dvs_x),
    .busy_o     (busy_x),
    .quotient_o (quo_x)
  );

  jabc_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd_y),
    .divisor_i  (dvs_y),
    .busy_o     (busy_y),
    .quotient_o (quo_y)
  );

  // state update per opcode, divider load and commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q  <= CENTRE_R;
      centre_y_q  <= CENTRE_R;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      calib_cnt_q <= '0;
      enabled_q   <= 1'b0;
      stable_q    <= 1'b0;
      prev_q      <= 1'b0;
      match_q     <= '0;
      final_q     <= 1'b0;
      need_div_q  <= 1'b0;
      active_q    <= 1'b0;
      pressed_q   <= 1'b0;
    end else if (cmd_i.exec) begin
      final_q    <= 1'b0;
      need_div_q <= 1'b0;
      active_q   <= 1'b0;
      pressed_q  <= 1'b0;
      case (op_q)
        OP_READ: begin
          active_q   <= enabled_q;
          need_div_q <= enabled_q;
          prev_q     <= prev_n;
          match_q    <= match_n;
          stable_q   <= stable_n;
          pressed_q  <= stable_n && !stable_q;
        end
        OP_CALIB: begin
          sum_x_q     <= sum_x_n;
          sum_y_q     <= sum_y_n;
          calib_cnt_q <= calib_full ? '0 : cnt_n;
          final_q     <= calib_full;
          need_div_q  <= calib_full;
        end
        OP_STOP: begin
          enabled_q <= 1'b0;
        end
        OP_INIT_BUTTON: begin
          stable_q <= rb_q;
          prev_q   <= rb_q;
          match_q  <= '0;
        end
        default: ;
      endcase
    end else if (cmd_i.div_start) begin
      if (final_q) begin
        sum_x_q <= '0;
        sum_y_q <= '0;
      end
    end else if (cmd_i.commit) begin
      if (final_q) begin
        centre_x_q <= quo_x[SB-1:0];
        centre_y_q <= quo_y[SB-1:0];
        enabled_q  <= 1'b1;
      end
    end
  end

  // prepared axis values
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      px_q <= px;
      py_q <= py;
    end
  end

  // result register
  logic signed [OUT_W-1:0] x_out_q, y_out_q;
  logic                    down_q, press_out_q, done_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      x_out_q     <= axis_result(quo_x, active_q, px_q);
      y_out_q     <= axis_result(quo_y, active_q, py_q);
      down_q      <= stable_q;
      press_out_q <= pressed_q;
      done_q      <= final_q;
    end
  end

  assign sts_o.need_div = need_div_q;
  assign sts_o.div_busy = busy_x || busy_y;

  assign x_out_o            = x_out_q;
  assign y_out_o            = y_out_q;
  assign key_held_o         = down_q;
  assign key_press_o        = press_out_q;
  assign calibration_done_o = done_q;

endmodule

// ===== hw/rtl/joystick_axis_button_conditioner_unit.sv =====
// top level of the joystick axis and button conditioner
//
// Takes one request at a time: read, calibration sample, stop axes or
// initialise button, and returns one result per request. A read with the
// axes enabled, and the calibration sample that completes the average, run
// each axis through its own restoring divider, one quotient bit per cycle
// (the divider length is 24 bits: sample width plus the width of AXIS_MAX,
// or the sum width if that is larger). Every other request skips the
// divider. A finished result waits in an output register, and the next
// request is taken while it waits. Configuration writes are taken in any
// cycle and are meant for an idle block.
module joystick_axis_button_conditioner_unit #(
  parameter int unsigned CALIB_SAMPLES = jabc_pkg::CALIB_SAMPLES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  jabc_req_if.sink   req_i,
  jabc_res_if.source res_o,
  jabc_cfg_if.sink   cfg_i
);

  import jabc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // configuration writes are always taken
  assign cfg_i.ready = 1'b1;

  // sequencing
  jabc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  jabc_datapath #(.CALIB_SAMPLES(CALIB_SAMPLES)) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_i.valid),
    .cfg_index_i        (cfg_i.index),
    .cfg_data_i         (cfg_i.data),
    .opcode_i           (req_i.opcode),
    .raw_x_i            (req_i.raw_x),
    .raw_y_i            (req_i.raw_y),
    .key_raw_i          (req_i.key_raw),
    .x_out_o            (res_o.x_out),
    .y_out_o            (res_o.y_out),
    .key_held_o         (res_o.key_held),
    .key_press_o        (res_o.key_press),
    .calibration_done_o (res_o.calibration_done)
  );

endmodule

// ===== tb/joystick_axis_button_conditioner_unit_tb.sv =====
// self-checking testbench of the joystick axis and button conditioner
module joystick_axis_button_conditioner_unit_tb;
  import jabc_pkg::*;

  localparam int CALIB_N      = CALIB_SAMPLES_DEF;
  localparam int RANDOM_ITEMS = 1600;
  localparam int SETTLE_CYC   = 40;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;

  // one conditioned reading as the block returns it
  typedef struct packed {
    logic signed [OUT_W-1:0] x_out;
    logic signed [OUT_W-1:0] y_out;
    logic                    key_held;
    logic                    key_press;
    logic                    calibration_done;
  } reading_t;

  logic clk_i;
  logic rst_ni;

  jabc_req_if req_bus ();
  jabc_res_if res_bus ();
  jabc_cfg_if cfg_bus ();

  joystick_axis_button_conditioner_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  // mirrored state of the conditioner
  int   ctr_x       = 2048;
  int   ctr_y       = 2048;
  int   acc_x       = 0;
  int   acc_y       = 0;
  int   acc_n       = 0;
  logic axes_on     = 1'b0;
  logic btn_stable  = 1'b0;
  logic btn_last    = 1'b0;
  int   btn_matches = 0;
  int   dz_reg      = 200;
  int   dbc_reg     = 2;

  reading_t pending_readings[$];
  int       mismatch_count = 0;
  int       items_sent     = 0;
  int       burst_left     = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  // clamp a value into the converter range
  function automatic int clip_sample(int v);
    if (v < 0) return 0;
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    return v;
  endfunction

  // recentre, deadzone, per-side scaling and clamp of one axis
  function automatic int axis_position(int raw, int centre);
    int value;
    int span;
    int mag;
    int scaled;
    value = raw - centre;
    if (value > -dz_reg && value < dz_reg) return 0;
    if (value > 0) begin
      span = int'(FULL_SCALE) - centre - dz_reg;
      mag  = value - dz_reg;
    end else begin
      span = centre - dz_reg;
      mag  = -value - dz_reg;
    end
    if (span <= 0) return 0;
    if (mag < 0) mag = 0;
    if (mag > span) mag = span;
    scaled = (mag * int'(AXIS_MAX)) / span;
    if (scaled > int'(AXIS_MAX)) scaled = int'(AXIS_MAX);
    return (value > 0) ? scaled : -scaled;
  endfunction

  // advance the mirrored state by one request and give its reading
  function automatic reading_t condition_request(op_e op, int rx, int ry, logic rb);
    reading_t r;
    logic     held_before;
    int       xo;
    int       yo;
    r  = '0;
    xo = 0;
    yo = 0;
    case (op)
      OP_READ: begin
        if (axes_on) begin
          xo = axis_position(rx, ctr_x);
          yo = axis_position(ry, ctr_y);
        end
        if (rb == btn_last) begin
          if (btn_matches < dbc_reg) btn_matches++;
        end else begin
          btn_last    = rb;
          btn_matches = 1;
        end
        held_before = btn_stable;
        if (btn_matches >= dbc_reg) btn_stable = btn_last;
        r.key_press = btn_stable && !held_before;
      end
      OP_CALIB: begin
        acc_x += rx;
        acc_y += ry;
        acc_n++;
        if (acc_n >= CALIB_N) begin
          ctr_x   = acc_x / CALIB_N;
          ctr_y   = acc_y / CALIB_N;
          acc_x   = 0;
          acc_y   = 0;
          acc_n   = 0;
          axes_on = 1'b1;
          r.calibration_done = 1'b1;
        end
      end
      OP_STOP: begin
        axes_on = 1'b0;
      end
      default: begin
        btn_stable  = rb;
        btn_last    = rb;
        btn_matches = 0;
      end
    endcase
    r.x_out    = OUT_W'(xo);
    r.y_out    = OUT_W'(yo);
    r.key_held = btn_stable;
    return r;
  endfunction

  // send one request, then keep bursts and gaps going
  task automatic send_request(op_e op, int rx, int ry, logic rb);
    int gap;
    req_bus.valid   <= 1'b1;
    req_bus.opcode  <= op;
    req_bus.raw_x   <= SAMPLE_BITS'(rx);
    req_bus.raw_y   <= SAMPLE_BITS'(ry);
    req_bus.key_raw <= rb;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    pending_readings.push_back(condition_request(op, rx & SAMPLE_MAX, ry & SAMPLE_MAX, rb));
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 8);
    end
  endtask

  // write both registers back to back on an idle block
  task automatic write_config(int deadzone, int debounce);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= REG_DEADZONE;
    cfg_bus.data  <= CFG_DATA_W'(deadzone);
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    dz_reg = deadzone;
    cfg_bus.index <= REG_DEBOUNCE;
    cfg_bus.data  <= CFG_DATA_W'(debounce);
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    dbc_reg = debounce;
    cfg_bus.valid <= 1'b0;
  endtask

  // hold off until every reading is back, then let the block go quiet
  task automatic settle_block();
    req_bus.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // calibration samples scattered around a chosen centre
  task automatic calibrate_around(int n, int cx, int cy, int spread, bit interleave);
    int k;
    for (k = 0; k < n; k++) begin
      if (interleave && $urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) == 0)
          send_request(OP_READ, $urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX),
                       1'($urandom_range(0, 1)));
        else
          send_request(OP_STOP, $urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX),
                       1'($urandom_range(0, 1)));
      end
      send_request(OP_CALIB,
                   clip_sample(cx + $urandom_range(0, 2 * spread) - spread),
                   clip_sample(cy + $urandom_range(0, 2 * spread) - spread),
                   1'($urandom_range(0, 1)));
    end
  endtask

  // compare one field of a reading
  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t %s mismatch expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // axes off after reset, button debounce at its reset count
  task automatic test_disabled_axes();
    send_request(OP_READ, 0, SAMPLE_MAX, 1'b0);
    send_request(OP_READ, SAMPLE_MAX, 0, 1'b1);
    send_request(OP_READ, 2048, 2048, 1'b1);
    send_request(OP_STOP, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    send_request(OP_READ, 0, 0, 1'b1);
    send_request(OP_INIT_BUTTON, 0, 0, 1'b0);
    send_request(OP_READ, 0, 0, 1'b1);
  endtask

  // full-scale sums, with a read and a stop while partly collected
  task automatic test_calibration_sums();
    int k;
    for (k = 0; k < CALIB_N; k++) begin
      if (k == 10) send_request(OP_READ, 2100, 2100, 1'b0);
      if (k == 20) send_request(OP_STOP, 0, 0, 1'b1);
      send_request(OP_CALIB, (k % 2 == 1) ? SAMPLE_MAX : 0, SAMPLE_MAX, k[0]);
    end
  endtask

  // deadzone edges and saturation beyond the span
  task automatic test_read_extremes();
    send_request(OP_READ, 0, 0, 1'b0);
    send_request(OP_READ, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    send_request(OP_READ, ctr_x + dz_reg - 1, ctr_y - dz_reg + 1, 1'b0);
    send_request(OP_READ, ctr_x - dz_reg, ctr_y - dz_reg, 1'b0);
    send_request(OP_READ, ctr_x + dz_reg + 1, ctr_y - dz_reg - 1, 1'b0);
  endtask

  // widest and narrowest deadzone, spans falling to zero
  task automatic test_deadzone_limits();
    settle_block();
    write_config(2047, 1);
    send_request(OP_READ, 0, 0, 1'b1);
    send_request(OP_READ, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    send_request(OP_READ, ctr_x, ctr_y, 1'b1);
    settle_block();
    write_config(0, 15);
    send_request(OP_READ, ctr_x, ctr_y, 1'b0);
    send_request(OP_READ, ctr_x + 1, 0, 1'b0);
    send_request(OP_READ, ctr_x - 1, SAMPLE_MAX, 1'b0);
  endtask

  // debounce count of zero, then a bouncing release and press
  task automatic test_button_debounce();
    settle_block();
    write_config(200, 0);
    send_request(OP_READ, 0, 0, 1'b1);
    send_request(OP_READ, 0, 0, 1'b0);
    send_request(OP_READ, 0, 0, 1'b1);
    settle_block();
    write_config(200, 3);
    send_request(OP_INIT_BUTTON, 0, 0, 1'b1);
    send_request(OP_READ, 0, 0, 1'b0);
    send_request(OP_READ, 0, 0, 1'b1);
    send_request(OP_READ, 0, 0, 1'b0);
    send_request(OP_READ, 0, 0, 1'b0);
    send_request(OP_READ, 0, 0, 1'b0);
    send_request(OP_READ, 0, 0, 1'b1);
    send_request(OP_READ, 0, 0, 1'b1);
    send_request(OP_READ, 0, 0, 1'b1);
  endtask

  // old centres stay in use until the last sample of a new calibration
  task automatic test_recalibration();
    settle_block();
    write_config(200, 2);
    calibrate_around(5, 600, 3500, 30, 1'b0);
    send_request(OP_READ, 0, SAMPLE_MAX, 1'b0);
    calibrate_around(CALIB_N - 5, 600, 3500, 30, 1'b0);
    send_request(OP_READ, 0, SAMPLE_MAX, 1'b0);
  endtask

  // phases of random settings, calibrations and read traffic
  task automatic test_random_traffic();
    int   start;
    int   dz;
    int   dbc;
    int   sel;
    int   reach;
    int   rx;
    int   ry;
    logic level;
    logic rb;
    bit   bouncy;
    level = 1'b0;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      settle_block();
      case ($urandom_range(0, 5))
        0:       dz = 0;
        1:       dz = 2047;
        2, 3:    dz = $urandom_range(0, 400);
        default: dz = $urandom_range(0, 2047);
      endcase
      case ($urandom_range(0, 5))
        0:       dbc = 0;
        1:       dbc = 1;
        2:       dbc = 15;
        default: dbc = $urandom_range(1, 15);
      endcase
      write_config(dz, dbc);
      bouncy = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) != 0)
        calibrate_around(CALIB_N, $urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX),
                         $urandom_range(0, 60), 1'b1);
      repeat ($urandom_range(60, 220)) begin
        // held button level with rare changes and optional contact bounce
        if ($urandom_range(0, 24) == 0) level = ~level;
        rb = (bouncy && $urandom_range(0, 5) == 0) ? ~level : level;
        reach = dz_reg + 400;
        if ($urandom_range(0, 2) == 0) begin
          rx = $urandom_range(0, SAMPLE_MAX);
          ry = $urandom_range(0, SAMPLE_MAX);
        end else begin
          rx = clip_sample(ctr_x + $urandom_range(0, 2 * reach) - reach);
          ry = clip_sample(ctr_y + $urandom_range(0, 2 * reach) - reach);
        end
        sel = $urandom_range(0, 39);
        if (sel < 36)       send_request(OP_READ, rx, ry, rb);
        else if (sel == 36) send_request(OP_STOP, rx, ry, rb);
        else if (sel == 37) send_request(OP_INIT_BUTTON, rx, ry, rb);
        else                send_request(OP_CALIB, rx, ry, rb);
      end
    end
  endtask

  // receiver ready on changing patterns
  initial begin : result_stall
    int mode;
    int run;
    mode = 0;
    run  = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (run == 0) begin
        mode = $urandom_range(0, 3);
        run  = $urandom_range(20, 120);
      end else begin
        run--;
      end
      case (mode)
        0:       res_bus.ready <= 1'b1;
        1:       res_bus.ready <= ($urandom_range(0, 1) == 1);
        2:       res_bus.ready <= ($urandom_range(0, 7) != 0);
        default: res_bus.ready <= ((run % 13) < 3);
      endcase
    end
  end

  // check each returned reading against the oldest prediction
  always @(posedge clk_i) begin : check_readings
    reading_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (pending_readings.size() == 0) begin
        $display("%0t unexpected result expected none actual x_out %0d y_out %0d", $time,
                 res_bus.x_out, res_bus.y_out);
        mismatch_count++;
      end else begin
        want = pending_readings.pop_front();
        compare_field("x_out", int'(want.x_out), int'(res_bus.x_out));
        compare_field("y_out", int'(want.y_out), int'(res_bus.y_out));
        compare_field("key_held", int'(want.key_held), int'(res_bus.key_held));
        compare_field("key_press", int'(want.key_press), int'(res_bus.key_press));
        compare_field("calibration_done", int'(want.calibration_done),
                      int'(res_bus.calibration_done));
      end
    end
  end

  // reset, directed tests, random traffic, final verdict
  initial begin
    rst_ni          <= 1'b0;
    req_bus.valid   <= 1'b0;
    req_bus.opcode  <= OP_READ;
    req_bus.raw_x   <= '0;
    req_bus.raw_y   <= '0;
    req_bus.key_raw <= 1'b0;
    cfg_bus.valid   <= 1'b0;
    cfg_bus.index   <= REG_DEADZONE;
    cfg_bus.data    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_disabled_axes();
    test_calibration_sums();
    test_read_extremes();
    test_deadzone_limits();
    test_button_debounce();
    test_recalibration();
    test_random_traffic();
    settle_block();
    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
